// ===== hdl/tvrc_pkg.sv =====
// shared types, register codes and constants for the turntable velocity ramp controller
// no dependencies; imported by every module of the block

package tvrc_pkg;

    // field and port widths
    localparam int ERR_W       = 16;
    localparam int MS_W        = 16;
    localparam int DRV_W       = 12;
    localparam int VEL_W       = 18;
    localparam int ANG_W       = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    // datapath widths
    localparam int PROD_W = 36;
    localparam int WORK_W = 36;
    localparam int TGT_W  = 25;
    localparam int STEP_W = 32;
    localparam int QUO_W  = 24;
    localparam int REM_W  = 10;

    // angle divider: radix-16 long division by a constant
    localparam int DIV_DIGITS  = 9;
    localparam int DIV_CNT_W   = 4;
    localparam int ANG_DIVISOR = 1000;

    // largest drive code
    localparam logic [DRV_W-1:0] DRIVE_MAX = 12'd4095;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DBAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VPV    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd6;

    // configuration reset values
    localparam logic        RST_ENABLE = 1'b1;
    localparam logic [15:0] RST_ACCEL  = 16'd131;
    localparam logic [11:0] RST_GAIN   = 12'd512;
    localparam logic [14:0] RST_DBAND  = 15'd715;
    localparam logic [11:0] RST_VPV    = 12'd1244;
    localparam logic [11:0] RST_CENTER = 12'd1250;
    localparam logic [16:0] RST_LIMIT  = 17'd65536;

    // multiplier operand select codes
    localparam logic [1:0] MUL_STEP = 2'd0;
    localparam logic [1:0] MUL_TGT  = 2'd1;
    localparam logic [1:0] MUL_DRV  = 2'd2;
    localparam logic [1:0] MUL_ANG  = 2'd3;

    typedef struct packed {
        logic        enable;
        logic [15:0] accel;
        logic [11:0] gain;
        logic [14:0] deadband;
        logic [11:0] vpv;
        logic [11:0] center;
        logic [16:0] limit;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       save_step;
        logic       ramp1;
        logic       ramp2;
        logic       clamp;
        logic       drive;
        logic       div_init;
        logic       div_step;
        logic       finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_status;

    // k times the angle divisor, k in 0..15
    function automatic logic [13:0] div_multiple(input logic [3:0] k);
        return 14'(k * ANG_DIVISOR);
    endfunction

endpackage

// ===== hdl/turntable_velocity_ramp_controller.sv =====
// top level of the turntable velocity ramp controller
// depends on tvrc_pkg, tvrc_cfg_regs, tvrc_ctrl and tvrc_datapath
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   heading_error, elapsed_ms
//  m_axis    out        m_axis_tvalid / m_axis_tready   drive_millivolts, turn_velocity,
//                                                       table_angle
//  cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
//  a new request is taken only once the last one is finished; the work is set by the
//  single shared multiplier (four products) and the 9-digit radix-16 divider for the
//  angle increment; s_axis_tready is high only while the sequencer is idle
//  a finished result waits in the output register while the next request is taken;
//  a stall on m_axis holds the sequencer in its last step until the register frees
//  synchronous active-low reset clears velocity, angle, sequencer and output valid
//  and loads the configuration defaults; configuration writes are taken every cycle

module turntable_velocity_ramp_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] heading_error, [31:16] elapsed_ms
    input  logic [tvrc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [11:0] drive_millivolts, [29:12] turn_velocity, [61:30] table_angle, [63:62] zero
    output logic [tvrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tvrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tvrc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tvrc_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    tvrc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tvrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tvrc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== hdl/tvrc_cfg_regs.sv =====
// configuration register file of the turntable velocity ramp controller
// depends on tvrc_pkg

module tvrc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tvrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tvrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tvrc_pkg::t_cfg                o_cfg
);
    import tvrc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, out of range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= RST_ENABLE;
            r_cfg.accel    <= RST_ACCEL;
            r_cfg.gain     <= RST_GAIN;
            r_cfg.deadband <= RST_DBAND;
            r_cfg.vpv      <= RST_VPV;
            r_cfg.center   <= RST_CENTER;
            r_cfg.limit    <= RST_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENABLE: r_cfg.enable   <= i_cfg_data[0];
                REG_ACCEL:  r_cfg.accel    <= i_cfg_data[15:0];
                REG_GAIN:   r_cfg.gain     <= i_cfg_data[11:0];
                REG_DBAND:  r_cfg.deadband <= i_cfg_data[14:0];
                REG_VPV:    r_cfg.vpv      <= i_cfg_data[11:0];
                REG_CENTER: r_cfg.center   <= i_cfg_data[11:0];
                REG_LIMIT:  r_cfg.limit    <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/tvrc_ctrl.sv =====
// sequencing state machine of the turntable velocity ramp controller
// depends on tvrc_pkg; drives the commands of tvrc_datapath

module tvrc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tvrc_pkg::t_status  i_status,
    output tvrc_pkg::t_cmd     o_cmd
);
    import tvrc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MSTEP = 4'd1;
    localparam logic [3:0] S_MTGT  = 4'd2;
    localparam logic [3:0] S_RAMP1 = 4'd3;
    localparam logic [3:0] S_RAMP2 = 4'd4;
    localparam logic [3:0] S_CLAMP = 4'd5;
    localparam logic [3:0] S_MDRV  = 4'd6;
    localparam logic [3:0] S_DRV   = 4'd7;
    localparam logic [3:0] S_DINIT = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MSTEP;
                end
            end
            S_MSTEP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_STEP;
                n_state       = S_MTGT;
            end
            S_MTGT: begin
                o_cmd.save_step = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MUL_TGT;
                n_state         = S_RAMP1;
            end
            S_RAMP1: begin
                o_cmd.ramp1 = 1'b1;
                n_state     = S_RAMP2;
            end
            S_RAMP2: begin
                o_cmd.ramp2 = 1'b1;
                n_state     = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_MDRV;
            end
            S_MDRV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DRV;
                n_state       = S_DRV;
            end
            S_DRV: begin
                o_cmd.drive   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ANG;
                n_state       = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_DIGITS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hdl/tvrc_datapath.sv =====
// datapath of the turntable velocity ramp controller: shared multiplier, ramp,
// clamp, drive, radix-16 angle divider and output register; depends on tvrc_pkg

module tvrc_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tvrc_pkg::t_cfg                   i_cfg,
    input  tvrc_pkg::t_cmd                   i_cmd,
    output tvrc_pkg::t_status                o_status,
    input  logic [tvrc_pkg::IN_TDATA_W-1:0]  i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tvrc_pkg::OUT_TDATA_W-1:0] o_out_data
);
    import tvrc_pkg::*;

    // item and working registers
    logic signed [ERR_W-1:0]  r_err;
    logic [MS_W-1:0]          r_ms;
    logic [STEP_W-1:0]        r_step;
    logic signed [TGT_W-1:0]  r_tgt;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [WORK_W-1:0] r_v;
    logic                     r_inc;
    logic                     r_dec;
    logic [DRV_W-1:0]         r_drive;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_dvd;
    logic [REM_W-1:0]         r_rem;
    logic [QUO_W-1:0]         r_quo;

    // state
    logic signed [VEL_W-1:0]  r_vel;
    logic [ANG_W-1:0]         r_ang;

    // output register
    logic                     r_out_valid;
    logic [DRV_W-1:0]         r_out_drive;
    logic [VEL_W-1:0]         r_out_vel;
    logic [ANG_W-1:0]         r_out_ang;

    logic signed [16:0]       err_ext;
    logic signed [16:0]       err_neg;
    logic signed [16:0]       db_ext;
    logic                     side_pos;
    logic                     side_neg;
    logic signed [18:0]       mul_a;
    logic signed [16:0]       mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [WORK_W-1:0] v0;
    logic signed [WORK_W-1:0] step_ext;
    logic signed [WORK_W-1:0] tgt_now;
    logic signed [WORK_W-1:0] tgt_reg;
    logic signed [WORK_W-1:0] lim_pos;
    logic signed [WORK_W-1:0] lim_neg;
    logic signed [WORK_W-1:0] v1;
    logic signed [WORK_W-1:0] v2;
    logic signed [WORK_W-1:0] v_cl;
    logic                     inc1;
    logic                     dec1;
    logic signed [20:0]       drv_sum;
    logic [DRV_W-1:0]         drv_sat;
    logic [PROD_W-1:0]        div_mag;
    logic [13:0]              div_cur;
    logic [3:0]               digit;
    logic [13:0]              div_rem;
    logic [ANG_W-1:0]         quo_ext;
    logic [ANG_W-1:0]         ang_inc;
    logic [ANG_W-1:0]         ang_next;

    // deadband side of the heading error
    assign err_ext  = {r_err[ERR_W-1], r_err};
    assign err_neg  = -err_ext;
    assign db_ext   = {2'b00, i_cfg.deadband};
    assign side_pos = (err_ext > db_ext);
    assign side_neg = (err_ext < -db_ext);

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_STEP: begin
                mul_a = {3'b000, i_cfg.accel};
                mul_b = {1'b0, r_ms};
            end
            MUL_TGT: begin
                mul_a = {7'b0000000, i_cfg.gain};
                mul_b = err_neg;
            end
            MUL_DRV: begin
                mul_a = {r_vel[VEL_W-1], r_vel};
                mul_b = {5'b00000, i_cfg.vpv};
            end
            default: begin
                mul_a = {r_vel[VEL_W-1], r_vel};
                mul_b = {1'b0, r_ms};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ramp operands
    assign v0       = {{(WORK_W-VEL_W){r_vel[VEL_W-1]}}, r_vel};
    assign step_ext = {{(WORK_W-STEP_W){1'b0}}, r_step};
    assign tgt_now  = {{(WORK_W-TGT_W){r_prod[28]}}, r_prod[28:4]};
    assign tgt_reg  = {{(WORK_W-TGT_W){r_tgt[TGT_W-1]}}, r_tgt};
    assign lim_pos  = {{(WORK_W-17){1'b0}}, i_cfg.limit};
    assign lim_neg  = -lim_pos;

    // first compare of the ramp, or the deadband decay step
    always_comb begin
        v1   = v0;
        inc1 = 1'b0;
        dec1 = 1'b0;
        if (side_pos) begin
            if (v0 > tgt_now) v1 = v0 - step_ext;
        end else if (side_neg) begin
            if (v0 < tgt_now) v1 = v0 + step_ext;
        end else if (v0 < 0) begin
            v1   = v0 + step_ext;
            inc1 = 1'b1;
        end else if (v0 > 0) begin
            v1   = v0 - step_ext;
            dec1 = 1'b1;
        end
    end

    // second compare of the ramp, or the stop at zero in the deadband
    always_comb begin
        v2 = r_v;
        if (side_pos) begin
            if (r_v < tgt_reg) v2 = r_v + step_ext;
        end else if (side_neg) begin
            if (r_v > tgt_reg) v2 = r_v - step_ext;
        end else if (r_inc && (r_v > 0)) begin
            v2 = '0;
        end else if (r_dec && (r_v < 0)) begin
            v2 = '0;
        end
    end

    // velocity limit
    always_comb begin
        v_cl = r_v;
        if (r_v > lim_pos) begin
            v_cl = lim_pos;
        end else if (r_v < lim_neg) begin
            v_cl = lim_neg;
        end
    end

    // drive: center plus scaled velocity (center alone when disabled), saturated
    always_comb begin
        if (i_cfg.enable) begin
            drv_sum = $signed({9'd0, i_cfg.center}) + $signed({r_prod[35], r_prod[35:16]});
        end else begin
            drv_sum = $signed({9'd0, i_cfg.center});
        end
        if (drv_sum < 0) begin
            drv_sat = '0;
        end else if (drv_sum > $signed({9'd0, DRIVE_MAX})) begin
            drv_sat = DRIVE_MAX;
        end else begin
            drv_sat = drv_sum[DRV_W-1:0];
        end
    end

    // divider input: magnitude, biased up by divisor minus one when negative
    assign div_mag = r_prod[PROD_W-1] ? (~r_prod + PROD_W'(ANG_DIVISOR)) : r_prod;

    // one quotient digit per step
    assign div_cur = {r_rem, r_dvd[PROD_W-1 -: 4]};

    always_comb begin
        digit = '0;
        for (int k = 1; k < 16; k++) begin
            if (div_cur >= div_multiple(4'(k))) digit = 4'(k);
        end
    end

    assign div_rem = div_cur - div_multiple(digit);

    // angle update
    assign quo_ext  = {{(ANG_W-QUO_W){1'b0}}, r_quo};
    assign ang_inc  = r_neg ? (~quo_ext + 1'b1) : quo_ext;
    assign ang_next = r_ang + ang_inc;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_err <= i_in_data[ERR_W-1:0];
            r_ms  <= i_in_data[ERR_W +: MS_W];
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.save_step) begin
            r_step <= r_prod[STEP_W-1:0];
        end
        if (i_cmd.ramp1) begin
            r_v   <= v1;
            r_tgt <= r_prod[28:4];
            r_inc <= inc1;
            r_dec <= dec1;
        end
        if (i_cmd.ramp2) begin
            r_v <= v2;
        end
        if (i_cmd.drive) begin
            r_drive <= drv_sat;
        end
        if (i_cmd.div_init) begin
            r_neg <= r_prod[PROD_W-1];
            r_dvd <= div_mag;
            r_rem <= '0;
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[PROD_W-5:0], 4'b0000};
            r_rem <= div_rem[REM_W-1:0];
            r_quo <= {r_quo[QUO_W-5:0], digit};
        end
        if (i_cmd.finish) begin
            r_out_drive <= r_drive;
            r_out_vel   <= r_vel;
            r_out_ang   <= ang_next;
        end
    end

    // velocity and angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= '0;
            r_ang <= '0;
        end else begin
            if (i_cmd.clamp) begin
                r_vel <= v_cl[VEL_W-1:0];
            end
            if (i_cmd.finish) begin
                r_ang <= ang_next;
            end
        end
    end

    // output request valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = {2'b00, r_out_ang, r_out_vel, r_out_drive};

endmodule

// ===== hdl/tvrc_checker.sv =====
// port-level checks for the turntable velocity ramp controller, bound to the top level
// depends on tvrc_pkg and turntable_velocity_ramp_controller

module tvrc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tvrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tvrc_pkg::*;

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // reset leaves no result pending
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("input ready right after a request was taken");

    // a result never appears the cycle after a request is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !$rose(m_axis_tvalid))
        else $error("result appeared too soon after a request");

    // results are produced only out of the busy phase
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while the block was idle");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind turntable_velocity_ramp_controller tvrc_checker u_tvrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb.sv =====
// self-checking testbench for the turntable velocity ramp controller
// depends on tvrc_pkg and the turntable_velocity_ramp_controller rtl; a local
// predictor of velocity, drive and angle checks every result under random idling

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tvrc_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 85;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int { SET_LOW, SET_HIGH, SET_RANDOM } t_setting_mode;

    typedef struct {
        logic [DRV_W-1:0]        drive;
        logic signed [VEL_W-1:0] velocity;
        logic [ANG_W-1:0]        angle;
    } t_ramp_result;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    // predictor state and register copy
    t_cfg cfg_model = '{enable: RST_ENABLE, accel: RST_ACCEL, gain: RST_GAIN,
                        deadband: RST_DBAND, vpv: RST_VPV, center: RST_CENTER,
                        limit: RST_LIMIT};
    logic signed [VEL_W-1:0] vel_model = '0;
    logic [ANG_W-1:0]        angle_model = '0;

    t_ramp_result expected_q[$];
    t_reg_write   reg_writes_q[$];
    int           fail_count = 0;
    int           idle_cycles = 0;
    bit           tx_burst = 1'b0;
    bit           rx_burst = 1'b0;

    turntable_velocity_ramp_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // division rounding toward minus infinity
    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    // one control step: ramp, clamp, drive and angle update
    function automatic t_ramp_result predict_ramp(input logic signed [ERR_W-1:0] heading,
                                                  input logic [MS_W-1:0] ms_in);
        longint       err, ms, ramp, band, target, vel, lim, drv;
        t_ramp_result r;
        err    = heading;
        ms     = ms_in;
        ramp   = longint'(cfg_model.accel) * ms;
        band   = longint'(cfg_model.deadband);
        target = floor_quot(-(longint'(cfg_model.gain) * err), 16);
        vel    = vel_model;
        lim    = longint'(cfg_model.limit);

        // the compare order follows the sign of the error
        if (err > band) begin
            if (vel > target) vel -= ramp;
            if (vel < target) vel += ramp;
        end else if (err < -band) begin
            if (vel < target) vel += ramp;
            if (vel > target) vel -= ramp;
        end else if (vel < 0) begin
            vel += ramp;
            if (vel > 0) vel = 0;
        end else if (vel > 0) begin
            vel -= ramp;
            if (vel < 0) vel = 0;
        end
        if (vel > lim) vel = lim;
        if (vel < -lim) vel = -lim;
        vel_model = vel[VEL_W-1:0];

        // drive saturates to the dac range
        if (cfg_model.enable)
            drv = longint'(cfg_model.center) + floor_quot(vel * longint'(cfg_model.vpv), 65536);
        else
            drv = longint'(cfg_model.center);
        if (drv < 0) drv = 0;
        if (drv > longint'(DRIVE_MAX)) drv = longint'(DRIVE_MAX);

        angle_model = angle_model + 32'(floor_quot(vel * ms, 1000));

        r.drive    = drv[DRV_W-1:0];
        r.velocity = vel_model;
        r.angle    = angle_model;
        return r;
    endfunction

    // register write as seen by the predictor
    function automatic void apply_reg(input t_reg_write w);
        case (w.index)
            REG_ENABLE: cfg_model.enable   = w.data[0];
            REG_ACCEL:  cfg_model.accel    = w.data[15:0];
            REG_GAIN:   cfg_model.gain     = w.data[11:0];
            REG_DBAND:  cfg_model.deadband = w.data[14:0];
            REG_VPV:    cfg_model.vpv      = w.data[11:0];
            REG_CENTER: cfg_model.center   = w.data[11:0];
            REG_LIMIT:  cfg_model.limit    = w.data[16:0];
            default: ;
        endcase
    endfunction

    // configuration channel driver, one request per queued write
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            apply_reg(reg_writes_q[0]);
            void'(reg_writes_q.pop_front());
        end
        if (reg_writes_q.size() != 0) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_writes_q[0].index;
            i_cfg_data  <= reg_writes_q[0].data;
        end else begin
            i_cfg_valid <= 1'b0;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        t_reg_write w;
        w.index = idx;
        w.data  = value;
        reg_writes_q.push_back(w);
        while (reg_writes_q.size() != 0) @(posedge i_clk);
    endtask

    // send one request and record its expected result
    task automatic send_step(input logic signed [ERR_W-1:0] heading,
                             input logic [MS_W-1:0] ms);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ms, heading};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(predict_ramp(heading, ms));
    endtask

    // hold off until every result is back and the sequencer is idle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // result sink with random stalls and stall-free stretches
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_ramp_result want;
        logic [DRV_W-1:0]        got_drive;
        logic signed [VEL_W-1:0] got_vel;
        logic [ANG_W-1:0]        got_angle;
        got_drive = m_axis_tdata[DRV_W-1:0];
        got_vel   = m_axis_tdata[DRV_W+VEL_W-1:DRV_W];
        got_angle = m_axis_tdata[DRV_W+VEL_W+ANG_W-1:DRV_W+VEL_W];
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("result with no request pending: %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (got_drive !== want.drive) begin
                    $error("drive_millivolts: expected %0d, got %0d", want.drive, got_drive);
                    fail_count++;
                end
                if (got_vel !== want.velocity) begin
                    $error("turn_velocity: expected %0d, got %0d", want.velocity, got_vel);
                    fail_count++;
                end
                if (got_angle !== want.angle) begin
                    $error("table_angle: expected %0d, got %0d",
                           $signed(want.angle), $signed(got_angle));
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // reset values, field extremes and the deadband edges
    task automatic test_defaults();
        send_step(16'sd0, 16'd1);
        send_step(16'sd32767, 16'd20);
        send_step(16'sd32767, 16'd65535);
        send_step(-16'sd32768, 16'd65535);
        send_step(-16'sd32768, 16'd300);
        send_step(16'sd716, 16'd10);
        send_step(-16'sd716, 16'd10);
        send_step(16'sd715, 16'd5);
        send_step(-16'sd715, 16'd5);
        send_step(16'sd0, 16'd100);
        send_step(16'sd0, 16'd0);
    endtask

    // drive clipping at both ends of the dac range
    task automatic test_drive_saturation();
        drain_results();
        write_reg(REG_CENTER, 17'd4095);
        write_reg(REG_VPV, 17'd4095);
        write_reg(REG_ACCEL, 17'd65535);
        write_reg(REG_LIMIT, 17'd131071);
        write_reg(REG_GAIN, 17'd4095);
        send_step(-16'sd32768, 16'd2);
        send_step(-16'sd32768, 16'd2);
        send_step(16'sd0, 16'd65535);
        drain_results();
        write_reg(REG_CENTER, 17'd0);
        send_step(16'sd32767, 16'd3);
        send_step(16'sd32767, 16'd3);
    endtask

    // stop mode, zero limit, deadband extremes, masking and an unused index
    task automatic test_disable_and_limits();
        drain_results();
        write_reg(REG_ENABLE, 17'h1FFFE);
        send_step(-16'sd20000, 16'd7);
        send_step(16'sd20000, 16'd7);
        drain_results();
        write_reg(REG_ENABLE, 17'd1);
        write_reg(REG_LIMIT, 17'd0);
        send_step(-16'sd32768, 16'd50);
        send_step(16'sd32767, 16'd50);
        drain_results();
        write_reg(REG_LIMIT, 17'd131071);
        write_reg(REG_DBAND, 17'd32767);
        send_step(16'sd32767, 16'd4);
        send_step(-16'sd32768, 16'd4);
        drain_results();
        write_reg(REG_DBAND, 17'd0);
        send_step(16'sd0, 16'd4);
        send_step(16'sd1, 16'd4);
        drain_results();
        write_reg(REG_UNUSED, 17'h1FFFF);
        send_step(16'sd100, 16'd4);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int width,
                                                           input t_setting_mode mode);
        case (mode)
            SET_LOW:  return '0;
            SET_HIGH: return CFG_DATA_W'((1 << width) - 1);
            default: begin
                // sometimes junk above the register width
                if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom);
                return CFG_DATA_W'($urandom_range(0, (1 << width) - 1));
            end
        endcase
    endfunction

    // random settings per phase, random requests within each
    task automatic test_random_settings();
        t_setting_mode   mode;
        int              e, band;
        logic [MS_W-1:0] ms;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            mode = (p == 0) ? SET_LOW : (p == 1) ? SET_HIGH : SET_RANDOM;
            write_reg(REG_ENABLE, pick_setting(1, mode));
            write_reg(REG_ACCEL, pick_setting(16, mode));
            write_reg(REG_GAIN, pick_setting(12, mode));
            write_reg(REG_DBAND, pick_setting(15, mode));
            write_reg(REG_VPV, pick_setting(12, mode));
            write_reg(REG_CENTER, pick_setting(12, mode));
            write_reg(REG_LIMIT, (mode == SET_LOW) ? 17'd1 : pick_setting(17, mode));
            tx_burst = (p % 3 == 2);
            band = int'(cfg_model.deadband);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
                case ($urandom_range(0, 9))
                    0, 1, 2:    e = int'($signed(16'($urandom)));
                    3, 4, 5, 6: e = int'($urandom_range(0, 4 * band + 8)) - 2 * band - 4;
                    7:          e = ($urandom_range(0, 1) ? band : -band)
                                    + int'($urandom_range(0, 2)) - 1;
                    default:    e = int'($urandom_range(0, 2000)) - 1000;
                endcase
                if (e > 32767) e = 32767;
                if (e < -32768) e = -32768;
                case ($urandom_range(0, 4))
                    0, 1, 2: ms = MS_W'($urandom_range(0, 20));
                    3:       ms = MS_W'($urandom_range(0, 1000));
                    default: ms = MS_W'($urandom);
                endcase
                send_step(ERR_W'(e), ms);
            end
        end
    endtask

    // reset, then the tests in turn
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_drive_saturation();
        test_disable_and_limits();
        test_random_settings();
        drain_results();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
